### design/jsrt_pkg.sv
// ----------------------------------------------------------------------------
// jsrt_pkg
// shared types, widths and codes for the job slot ring table
// ----------------------------------------------------------------------------
package jsrt_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = 7;
    localparam int MAX_EXP = 64;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_EXPIRE   = 2'd1,
        MODE_DISPATCH = 2'd2,
        MODE_COLLECT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_NULL = 2'd0,
        ST_PEND = 2'd1,
        ST_PROG = 2'd2,
        ST_DONE = 2'd3
    } t_jstate;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_NONE_PEND = 3'd3,
        STS_NONE_EXP  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] job_serial;
        logic [31:0] job_expires;
        logic [31:0] job_tag;
        logic [31:0] now_time;
        logic [6:0]  expire_limit;
        logic [5:0]  slot;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  out_slot;
        logic [31:0] out_serial;
        logic [31:0] out_expires;
        logic [31:0] out_tag;
        logic [1:0]  out_state;
        logic [6:0]  expired_count;
        logic        last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic rd;         // read slot at cursor into read registers
        logic wr_add;     // write add job at its target slot
        logic emit;       // fill result register for add, dispatch, collect
        logic emit_err;   // fill error result
        logic step;       // expire walk one step
        logic finish;     // apply pointer updates for current mode
        logic flush;      // move held expire word into result register
        logic flush_last; // held word is the final one of the walk
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       walk_done;   // expire must stop at this slot (after handling)
        logic       hit;         // current slot is live and expired
        logic       err;         // current request fails
        logic [2:0] err_code;
        logic       cnt_zero;
    } t_sts;

endpackage

### design/jsrt_if.sv
// ----------------------------------------------------------------------------
// jsrt_if
// valid/ready channels carrying an input word, a result word or a ring size
// ----------------------------------------------------------------------------
interface jsrt_in_if;
    import jsrt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface jsrt_out_if;
    import jsrt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface jsrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/jsrt_dp.sv
// ----------------------------------------------------------------------------
// jsrt_dp
// slot memories, pointers, state bits and result register
// ----------------------------------------------------------------------------
module jsrt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jsrt_pkg::t_in_word  i_in,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data,
    input  jsrt_pkg::t_ctl      i_ctl,
    output jsrt_pkg::t_sts      o_sts,
    output jsrt_pkg::t_out_word o_res
);
    import jsrt_pkg::*;

    logic [IDX_W:0] r_size;
    t_idx           r_head, r_tail, r_disp, r_cur;
    t_in_word       r_in;
    t_jstate        mem_state [SLOTS];
    logic           r_vld [SLOTS];
    logic [31:0]    mem_serial [SLOTS];
    logic [31:0]    mem_expires [SLOTS];
    logic [31:0]    mem_tag [SLOTS];
    t_jstate        r_rd_state;
    logic [31:0]    r_rd_serial, r_rd_expires, r_rd_tag;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] w_limit;
    t_out_word      r_res;
    t_out_word      r_hold;

    logic [IDX_W:0] n_size;
    t_idx           w_size_m1;
    t_idx           w_cur_inc, w_add_tgt, w_st_addr;
    logic           w_slot_oob, w_live, w_late, w_st_we;
    t_jstate        w_st_data;
    t_out_word      w_err_res, w_job_res, w_exp_res, w_flush_res;

    function automatic t_idx f_inc(t_idx a, t_idx last_idx);
        t_idx r;
        r = (a == last_idx) ? '0 : a + 1'b1;
        return r;
    endfunction

    always_comb begin
        if (i_cfg_data == '0) begin
            n_size = (IDX_W+1)'(1);
        end else if (i_cfg_data > 7'(SLOTS)) begin
            n_size = (IDX_W+1)'(SLOTS);
        end else begin
            n_size = (IDX_W+1)'(i_cfg_data);
        end
        w_size_m1  = IDX_W'(r_size - 1'b1);
        w_cur_inc  = f_inc(r_cur, w_size_m1);
        // add: an occupied tail slot moves the job one slot on
        w_add_tgt  = (r_rd_state != ST_NULL) ? w_cur_inc : r_cur;
        w_limit    = (r_in.expire_limit > 7'(MAX_EXP)) ? 7'(MAX_EXP) : r_in.expire_limit;
        w_slot_oob = ({1'b0, r_in.slot} >= 7'(r_size));
        w_live     = (r_rd_state == ST_PEND) || (r_rd_state == ST_PROG);
        w_late     = (r_rd_expires > r_in.now_time);
    end

    // status toward the controller, about the slot at cursor
    always_comb begin
        o_sts          = '0;
        o_sts.mode     = r_in.mode;
        o_sts.cnt_zero = (r_cnt == '0);
        o_sts.err_code = STS_OK;
        case (t_mode'(r_in.mode))
            MODE_ADD: begin
                o_sts.err      = (r_rd_state != ST_NULL) && (w_cur_inc == r_head);
                o_sts.err_code = STS_FULL;
            end
            MODE_EXPIRE: begin
                o_sts.hit       = (r_cnt < w_limit) && w_live && !w_late;
                o_sts.walk_done = (r_cnt >= w_limit) || (w_live && w_late)
                                  || (r_cur == r_tail);
            end
            MODE_DISPATCH: begin
                o_sts.err      = (r_rd_state != ST_PEND);
                o_sts.err_code = STS_NONE_PEND;
            end
            MODE_COLLECT: begin
                o_sts.err = w_slot_oob || (r_rd_state == ST_NULL)
                            || (r_rd_serial != r_in.job_serial);
                o_sts.err_code = STS_NOT_FOUND;
            end
            default: ;
        endcase
    end

    // single write port of the state memory
    always_comb begin
        w_st_we   = 1'b0;
        w_st_addr = r_cur;
        w_st_data = ST_NULL;
        if (i_ctl.wr_add) begin
            w_st_we   = 1'b1;
            w_st_addr = w_add_tgt;
            w_st_data = ST_PEND;
        end else if (i_ctl.step && o_sts.hit) begin
            w_st_we = 1'b1;
        end else if (i_ctl.finish && t_mode'(r_in.mode) == MODE_DISPATCH) begin
            w_st_we   = 1'b1;
            w_st_data = ST_PROG;
        end else if (i_ctl.finish && t_mode'(r_in.mode) == MODE_COLLECT) begin
            w_st_we = 1'b1;
        end
    end

    // result words
    always_comb begin
        w_err_res        = '0;
        w_err_res.status = (t_mode'(r_in.mode) == MODE_EXPIRE) ? STS_NONE_EXP
                                                                : o_sts.err_code;
        w_err_res.last   = 1'b1;

        w_job_res               = '0;
        w_job_res.status        = STS_OK;
        w_job_res.out_slot      = 6'(r_cur);
        w_job_res.out_serial    = r_rd_serial;
        w_job_res.out_expires   = r_rd_expires;
        w_job_res.out_tag       = r_rd_tag;
        w_job_res.out_state     = ST_DONE;
        w_job_res.expired_count = '0;
        w_job_res.last          = 1'b1;
        case (t_mode'(r_in.mode))
            MODE_ADD: begin
                w_job_res.out_slot    = 6'(w_add_tgt);
                w_job_res.out_serial  = r_in.job_serial;
                w_job_res.out_expires = r_in.job_expires;
                w_job_res.out_tag     = r_in.job_tag;
                w_job_res.out_state   = ST_PEND;
            end
            MODE_DISPATCH: begin
                w_job_res.out_state = ST_PROG;
            end
            default: ;
        endcase

        w_exp_res               = '0;
        w_exp_res.status        = STS_OK;
        w_exp_res.out_slot      = 6'(r_cur);
        w_exp_res.out_serial    = r_rd_serial;
        w_exp_res.out_expires   = r_rd_expires;
        w_exp_res.out_tag       = r_rd_tag;
        w_exp_res.out_state     = r_rd_state;
        w_exp_res.expired_count = r_cnt + 1'b1;
        w_exp_res.last          = 1'b0;

        w_flush_res      = r_hold;
        w_flush_res.last = i_ctl.flush_last;
    end

    // memory ports: one write, one registered read at the cursor
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_state   <= r_vld[r_cur] ? mem_state[r_cur] : ST_NULL;
            r_rd_serial  <= mem_serial[r_cur];
            r_rd_expires <= mem_expires[r_cur];
            r_rd_tag     <= mem_tag[r_cur];
        end
        if (i_ctl.wr_add) begin
            mem_serial[w_add_tgt]  <= r_in.job_serial;
            mem_expires[w_add_tgt] <= r_in.job_expires;
            mem_tag[w_add_tgt]     <= r_in.job_tag;
        end
        if (w_st_we) begin
            mem_state[w_st_addr] <= w_st_data;
        end
        if (i_ctl.load) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= (IDX_W+1)'(SLOTS);
            r_head <= '0;
            r_tail <= '0;
            r_disp <= '0;
            r_cur  <= '0;
            r_cnt  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_size <= n_size;
                if ({1'b0, r_head} >= n_size) r_head <= '0;
                if ({1'b0, r_tail} >= n_size) r_tail <= '0;
                if ({1'b0, r_disp} >= n_size) r_disp <= '0;
            end
            if (i_ctl.load) begin
                r_cnt <= '0;
                case (t_mode'(i_in.mode))
                    MODE_ADD:      r_cur <= r_tail;
                    MODE_EXPIRE:   r_cur <= r_head;
                    MODE_DISPATCH: r_cur <= r_disp;
                    default:       r_cur <= i_in.slot;
                endcase
            end
            if (w_st_we) begin
                r_vld[w_st_addr] <= 1'b1;
            end
            if (i_ctl.step) begin
                if (o_sts.hit) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (!o_sts.walk_done) begin
                    r_cur <= w_cur_inc;
                end
            end
            if (i_ctl.finish) begin
                case (t_mode'(r_in.mode))
                    MODE_EXPIRE: begin
                        r_head <= r_cur;
                        // a slot removed in this step is null now
                        if (r_rd_state != ST_PROG || o_sts.hit) r_disp <= r_cur;
                    end
                    MODE_DISPATCH: begin
                        if (r_disp != r_tail) r_disp <= w_cur_inc;
                    end
                    MODE_COLLECT: begin
                        if (r_cur == r_head && r_cur != r_tail) r_head <= w_cur_inc;
                    end
                    default: ;
                endcase
            end
            if (i_ctl.wr_add) begin
                // old tail stays non-pending only when it was in progress or done
                if (r_rd_state != ST_PEND && r_rd_state != ST_NULL) r_disp <= w_add_tgt;
                r_tail <= w_add_tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_err) begin
            r_res <= w_err_res;
        end else if (i_ctl.emit) begin
            r_res <= w_job_res;
        end else if (i_ctl.flush) begin
            r_res <= w_flush_res;
        end
        // expire word waits here until the next one or the end of the walk
        if (i_ctl.step && o_sts.hit) begin
            r_hold <= w_exp_res;
        end
    end

    assign o_res = r_res;

endmodule

### design/jsrt_ctrl.sv
// ----------------------------------------------------------------------------
// jsrt_ctrl
// sequencer for add, expire walk, dispatch and collect
// ----------------------------------------------------------------------------
module jsrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  jsrt_pkg::t_sts i_sts,
    output jsrt_pkg::t_ctl o_ctl
);
    import jsrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE, S_READ, S_EXEC, S_DRAIN
    } t_fsm;

    t_fsm r_fsm;
    logic r_out_valid;
    logic w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_fsm == S_IDLE) && w_out_free;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctl = '0;
        case (r_fsm)
            S_IDLE: o_ctl.load = i_in_valid && w_out_free;
            S_READ: o_ctl.rd = 1'b1;
            S_EXEC: begin
                if (w_out_free) begin
                    case (t_mode'(i_sts.mode))
                        MODE_EXPIRE: begin
                            // a new hit pushes out the word held from the last one
                            o_ctl.flush  = i_sts.hit && !i_sts.cnt_zero;
                            o_ctl.step   = 1'b1;
                            o_ctl.finish = i_sts.walk_done;
                        end
                        MODE_ADD: begin
                            o_ctl.emit_err = i_sts.err;
                            o_ctl.wr_add   = !i_sts.err;
                            o_ctl.emit     = !i_sts.err;
                        end
                        default: begin
                            o_ctl.emit_err = i_sts.err;
                            o_ctl.emit     = !i_sts.err;
                            o_ctl.finish   = !i_sts.err;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    if (i_sts.cnt_zero) begin
                        o_ctl.emit_err = 1'b1;
                    end else begin
                        o_ctl.flush      = 1'b1;
                        o_ctl.flush_last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_ctl.emit || o_ctl.emit_err || o_ctl.flush
                           || (r_out_valid && !i_out_ready);
            case (r_fsm)
                S_IDLE: if (o_ctl.load) r_fsm <= S_READ;
                S_READ: r_fsm <= S_EXEC;
                S_EXEC: begin
                    if (w_out_free) begin
                        if (t_mode'(i_sts.mode) == MODE_EXPIRE) begin
                            r_fsm <= i_sts.walk_done ? S_DRAIN : S_READ;
                        end else begin
                            r_fsm <= S_IDLE;
                        end
                    end
                end
                S_DRAIN: if (w_out_free) r_fsm <= S_IDLE;
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

endmodule

### design/job_slot_ring_table_top.sv
// ----------------------------------------------------------------------------
// job_slot_ring_table_top
// ring of job slots with add, expire, dispatch and collect requests
// ----------------------------------------------------------------------------
// Add, dispatch and collect pass through an accept, a slot memory read and
// an execute step; the result word is registered in the execute step and
// the next request is taken once the result register is free. Expire
// walks the ring from the head with a read step then a check step for each
// slot visited, set by the single registered read port of the slot memory,
// and ends with a drain step. Each expired job's word is held back until the
// next expired job is found or the walk ends, so the final word carries
// last; a walk that removes nothing gives one none-expired word. A stalled
// result word holds the sequencer in place. Write the ring size only while
// no request is in flight.
module job_slot_ring_table_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jsrt_in_if.sink   i_in,
    jsrt_out_if.source o_out,
    jsrt_cfg_if.sink  i_cfg
);
    import jsrt_pkg::*;

    t_ctl      ctl;
    t_sts      sts;
    t_out_word res;

    assign i_cfg.ready = 1'b1;
    assign o_out.data  = res;

    jsrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    jsrt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in.data),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_res      (res)
    );

endmodule

### design/jsrt_chk.sv
// ----------------------------------------------------------------------------
// jsrt_chk
// port level checks on the job slot ring table
// ----------------------------------------------------------------------------
module jsrt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [1:0]  i_out_state,
    input logic        i_last
);
    import jsrt_pkg::*;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STS_OK |-> i_last)
        else $error("error word without last");

    a_err_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STS_OK |-> i_out_state == ST_NULL)
        else $error("error word carries a job state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("word dropped while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while busy");

endmodule

bind job_slot_ring_table_top jsrt_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.data.status),
    .i_out_state (o_out.data.out_state),
    .i_last      (o_out.data.last)
);
